// File: rtl/core/lats_pkg.sv
// Shared types, command codes and the cell update rule for the torus life unit.
package lats_pkg;

	localparam int unsigned COL_W = 5;
	localparam int unsigned ROW_W = 4;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_STEP  = 2'd1,
		CMD_READ  = 2'd2
	} cmd_e;

	typedef struct packed {
		cmd_e             command;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             cell_in;
	} cmd_item_t;

	typedef struct packed {
		logic cell_out;
		logic finished;
	} res_item_t;

	// Broadcast to every row cell for the transfer being taken this cycle.
	typedef struct packed {
		logic             wr_en;
		logic             step_en;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             cell_in;
	} row_ctrl_t;

	// Returned by each row cell.
	typedef struct packed {
		logic rd_bit;
		logic live;
		logic changed;
	} row_stat_t;

	localparam logic [3:0] BIRTH_CNT   = 4'd3;
	localparam logic [3:0] SURVIVE_CNT = 4'd2;

	function automatic logic next_state(input logic self, input logic [7:0] nb);
		logic [3:0] cnt;
		cnt = 4'({3'b000, nb[0]}) + 4'({3'b000, nb[1]}) + 4'({3'b000, nb[2]})
			+ 4'({3'b000, nb[3]}) + 4'({3'b000, nb[4]}) + 4'({3'b000, nb[5]})
			+ 4'({3'b000, nb[6]}) + 4'({3'b000, nb[7]});
		return (cnt == BIRTH_CNT) || (self && (cnt == SURVIVE_CNT));
	endfunction

endpackage

// File: rtl/core/life_automaton_torus_step_unit.sv
// Top level of the toroidal life grid: row cell chain, result stage and handshake.
// A taken command is registered in stage 1 and then in the result register, from where
// its result can be transferred.
// Throughput: one command per cycle unless the result stalls, steps included; rows update together.
// A step's per-row live/changed flags are registered, then ORed on the way to the result.
// Reset (arst_n low) clears every cell to dead at once and empties both result stages.
module life_automaton_torus_step_unit import lats_pkg::*; #(
	parameter int unsigned GRID_COLS = 32,
	parameter int unsigned GRID_ROWS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_item_t cmd_item,
	output logic      res_valid,
	input  logic      res_stall,
	output res_item_t res_item
);

	// Row outputs of the chain; each cell sees the rows either side of it,
	// with the top and bottom rows as neighbours of each other.
	logic [GRID_COLS-1:0] row_bits [GRID_ROWS];
	row_stat_t            stat     [GRID_ROWS];
	logic [GRID_ROWS-1:0] rd_vec;
	logic [GRID_ROWS-1:0] live_vec;
	logic [GRID_ROWS-1:0] chg_vec;
	row_ctrl_t            cell_ctrl;

	logic      accept;
	logic      move;
	logic      valid_s1;
	cmd_e      cmd_s1;
	logic      rd_s1;
	logic      res_valid_q;
	res_item_t res_q;
	res_item_t res_next;

	// the grid changes on the very edge a command is taken, so a read
	// right behind a write or a step sees the updated cells
	assign accept            = cmd_valid & ~cmd_stall;
	assign cell_ctrl.wr_en   = accept & (cmd_item.command == CMD_WRITE);
	assign cell_ctrl.step_en = accept & (cmd_item.command == CMD_STEP);
	assign cell_ctrl.col     = cmd_item.col;
	assign cell_ctrl.row     = cmd_item.row;
	assign cell_ctrl.cell_in = cmd_item.cell_in;

	for (genvar r = 0; r < GRID_ROWS; r++) begin : g_row
		localparam int unsigned UP = (r == 0) ? GRID_ROWS - 1 : r - 1;
		localparam int unsigned DN = (r == GRID_ROWS - 1) ? 0 : r + 1;

		lats_row_cell #(
			.COLS    (GRID_COLS),
			.ROW_IDX (r)
		) u_row (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (cell_ctrl),
			.up_row (row_bits[UP]),
			.dn_row (row_bits[DN]),
			.cells  (row_bits[r]),
			.stat   (stat[r])
		);

		assign rd_vec[r]   = stat[r].rd_bit;
		assign live_vec[r] = stat[r].live;
		assign chg_vec[r]  = stat[r].changed;
	end

	// Stage 1 holds the command kind and read bit. It drains into the result
	// register whenever that is free or being taken, so the input can still
	// take one command while a finished result waits downstream.
	assign move      = valid_s1 & (~res_valid_q | ~res_stall);
	assign cmd_stall = valid_s1 & ~move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_item.command;
			rd_s1  <= |rd_vec;
		end
	end

	// Step flags stay put until the next step, which cannot be taken before
	// this one has left stage 1, so reducing them here is safe.
	always_comb begin
		res_next = '0;
		case (cmd_s1)
			CMD_READ: res_next.cell_out = rd_s1;
			CMD_STEP: res_next.finished = ~(|live_vec) | ~(|chg_vec);
			default:  res_next = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (move) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule

// File: rtl/core/lats_row_cell.sv
// One grid row: its cell registers, the life rule per column, and cell access.
module lats_row_cell import lats_pkg::*; #(
	parameter int unsigned COLS    = 32,
	parameter int unsigned ROW_IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  row_ctrl_t       ctrl,
	input  logic [COLS-1:0] up_row,
	input  logic [COLS-1:0] dn_row,
	output logic [COLS-1:0] cells,
	output row_stat_t       stat
);

	logic [COLS-1:0] cells_q;
	logic [COLS-1:0] next_row;
	logic [COLS-1:0] wr_row;
	logic            row_hit;
	logic            rd_bit;
	logic            live_q;
	logic            chg_q;

	assign row_hit = (int'(ctrl.row) == ROW_IDX);

	// neighbour taps wrap at both ends of the row
	for (genvar c = 0; c < COLS; c++) begin : g_col
		localparam int unsigned LF = (c == 0) ? COLS - 1 : c - 1;
		localparam int unsigned RT = (c == COLS - 1) ? 0 : c + 1;
		assign next_row[c] = next_state(cells_q[c], {up_row[LF], up_row[c], up_row[RT],
			cells_q[LF], cells_q[RT], dn_row[LF], dn_row[c], dn_row[RT]});
	end

	// column decode; an off-grid column matches nothing
	always_comb begin
		wr_row = cells_q;
		rd_bit = 1'b0;
		for (int c = 0; c < COLS; c++) begin
			if (int'(ctrl.col) == c) begin
				wr_row[c] = ctrl.cell_in;
				rd_bit    = cells_q[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_q <= '0;
			live_q  <= 1'b0;
			chg_q   <= 1'b0;
		end else if (ctrl.step_en) begin
			cells_q <= next_row;
			live_q  <= |next_row;
			chg_q   <= (next_row != cells_q);
		end else if (ctrl.wr_en && row_hit) begin
			cells_q <= wr_row;
		end
	end

	assign cells        = cells_q;
	assign stat.rd_bit  = row_hit & rd_bit;
	assign stat.live    = live_q;
	assign stat.changed = chg_q;

endmodule

// File: rtl/core/lats_checker.sv
// Port-level checks for the torus life unit, bound to the top level.
module lats_checker import lats_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      cmd_valid,
	input logic      cmd_stall,
	input logic      res_valid,
	input logic      res_stall,
	input res_item_t res_item
);

	// a held result keeps its value
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("stalled result changed or dropped");

	// nothing comes out on the first cycle out of reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !res_valid)
		else $error("result shown straight after reset");

	// every taken command is followed by a result on show
	a_result_due: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> ##1 res_valid)
		else $error("result missing after command transfer");

	// the input only backs up behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> res_valid && res_stall)
		else $error("input stalled without downstream back-pressure");

endmodule

bind life_automaton_torus_step_unit lats_checker u_lats_checker (.*);

// File: test/tb_top.sv
// Self-checking testbench for the toroidal life grid step unit.
`timescale 1ns / 1ps

module tb_top;
	import lats_pkg::*;

	localparam int unsigned GRID_COLS = 32;
	localparam int unsigned GRID_ROWS = 16;

	// Neighbour counts of the life rule.
	localparam int unsigned NB_BIRTH   = 3;
	localparam int unsigned NB_KEEP_LO = 2;

	// Command code with no meaning to the block.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int unsigned IDLE_PCT  = 38;
	localparam int unsigned MAX_SHOWN = 10;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	cmd_item_t cmd_item = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_item_t res_item;

	// Shadow copy of the grid, one word per row, bit index = column.
	logic [GRID_COLS-1:0] shadow_grid [GRID_ROWS];
	// Results still owed by the block, oldest first.
	res_item_t            awaited_cell_flags [$];
	int unsigned          mismatch_count = 0;
	int unsigned          send_idle_pct = IDLE_PCT;
	int unsigned          res_idle_pct = IDLE_PCT;

	life_automaton_torus_step_unit #(
		.GRID_COLS(GRID_COLS),
		.GRID_ROWS(GRID_ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_item(cmd_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item(res_item)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Result side back-pressure, redrawn every falling edge.
	always @(negedge clk) begin
		res_stall <= ($urandom_range(99) < res_idle_pct);
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	// One generation on the torus; returns the finished flag
	// (new grid empty, or no cell changed).
	function automatic logic advance_generation();
		logic [GRID_COLS-1:0] nxt [GRID_ROWS];
		int unsigned up, dn, lf, rt, n;
		logic any_live, changed, nv;
		any_live = 1'b0;
		changed  = 1'b0;
		for (int unsigned r = 0; r < GRID_ROWS; r++) begin
			up = (r == 0) ? GRID_ROWS - 1 : r - 1;
			dn = (r + 1 == GRID_ROWS) ? 0 : r + 1;
			for (int unsigned c = 0; c < GRID_COLS; c++) begin
				lf = (c == 0) ? GRID_COLS - 1 : c - 1;
				rt = (c + 1 == GRID_COLS) ? 0 : c + 1;
				n = shadow_grid[up][lf] + shadow_grid[up][c] + shadow_grid[up][rt]
					+ shadow_grid[r][lf] + shadow_grid[r][rt]
					+ shadow_grid[dn][lf] + shadow_grid[dn][c] + shadow_grid[dn][rt];
				if (shadow_grid[r][c])
					nv = (n == NB_KEEP_LO) || (n == NB_BIRTH);
				else
					nv = (n == NB_BIRTH);
				nxt[r][c] = nv;
				any_live |= nv;
				if (nv != shadow_grid[r][c])
					changed = 1'b1;
			end
		end
		shadow_grid = nxt;
		return !any_live || !changed;
	endfunction

	// Apply one command to the shadow grid and return the result it owes.
	function automatic res_item_t life_apply_cmd(input cmd_item_t it);
		res_item_t r;
		logic on_grid;
		r = '0;
		on_grid = (int'(it.col) < GRID_COLS) && (int'(it.row) < GRID_ROWS);
		case (it.command)
			CMD_WRITE: begin
				if (on_grid)
					shadow_grid[it.row][it.col] = it.cell_in;
			end
			CMD_STEP: begin
				r.finished = advance_generation();
			end
			CMD_READ: begin
				if (on_grid)
					r.cell_out = shadow_grid[it.row][it.col];
			end
			default: ;   // unused code: no effect, zero result
		endcase
		return r;
	endfunction

	function automatic cmd_item_t make_cmd(input logic [1:0] code, input int unsigned col,
			input int unsigned row, input logic val);
		cmd_item_t it;
		it.command = cmd_e'(code);
		it.col     = col[COL_W-1:0];
		it.row     = row[ROW_W-1:0];
		it.cell_in = val;
		return it;
	endfunction

	// ---------------------------------------------------------------
	// Driving and checking
	// ---------------------------------------------------------------

	// Offer one command, idling at random first; prediction is made at the
	// edge where the transfer is taken, so the expectation order is the
	// transfer order.
	task automatic send_cmd(input cmd_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item  <= it;
		do @(posedge clk); while (cmd_stall);
		awaited_cell_flags.push_back(life_apply_cmd(it));
	endtask

	task automatic send_fields(input logic [1:0] code, input int unsigned col,
			input int unsigned row, input logic val);
		send_cmd(make_cmd(code, col, row, val));
	endtask

	// Drop valid and hold off until every owed result has come back.
	task automatic drain_results();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (awaited_cell_flags.size() != 0)
			@(posedge clk);
	endtask

	task automatic flag_mismatch(input string what, input string want_s, input string got_s);
		mismatch_count++;
		if (mismatch_count <= MAX_SHOWN)
			$display("%0t mismatch %s: expected %s, got %s", $realtime, what, want_s, got_s);
	endtask

	// Every result transfer is held against the oldest expectation.
	always @(posedge clk) begin
		res_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (awaited_cell_flags.size() == 0) begin
				flag_mismatch("unexpected result", "nothing",
					$sformatf("cell_out=%0b finished=%0b",
						res_item.cell_out, res_item.finished));
			end else begin
				want = awaited_cell_flags.pop_front();
				if (res_item.cell_out !== want.cell_out)
					flag_mismatch("cell_out", $sformatf("%0b", want.cell_out),
						$sformatf("%0b", res_item.cell_out));
				if (res_item.finished !== want.finished)
					flag_mismatch("finished", $sformatf("%0b", want.finished),
						$sformatf("%0b", res_item.finished));
			end
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Corners, the unused code, empty-grid step, an oscillator across the
	// wrap and a still life straddling the corner across both wraps.
	task automatic test_directed();
		send_fields(CMD_READ, 5, 5, 1'b1);                        // untouched cell reads dead
		send_fields(CMD_WRITE, 0, 0, 1'b1);
		send_fields(CMD_WRITE, GRID_COLS - 1, GRID_ROWS - 1, 1'b1);
		send_fields(CMD_READ, 0, 0, 1'b0);
		send_fields(CMD_READ, GRID_COLS - 1, GRID_ROWS - 1, 1'b0);
		send_fields(CMD_UNUSED, GRID_COLS - 1, GRID_ROWS - 1, 1'b1); // must change nothing
		send_fields(CMD_READ, GRID_COLS - 1, GRID_ROWS - 1, 1'b0);
		send_fields(CMD_STEP, 0, 0, 1'b0);                        // lone cells die: empty
		send_fields(CMD_STEP, GRID_COLS - 1, GRID_ROWS - 1, 1'b1); // empty stays empty
		// blinker on the bottom row, wrapping in columns
		send_fields(CMD_WRITE, GRID_COLS - 2, GRID_ROWS - 1, 1'b1);
		send_fields(CMD_WRITE, GRID_COLS - 1, GRID_ROWS - 1, 1'b1);
		send_fields(CMD_WRITE, 0, GRID_ROWS - 1, 1'b1);
		send_fields(CMD_STEP, 0, 0, 1'b0);                        // turns vertical, wraps rows
		send_fields(CMD_READ, GRID_COLS - 1, 0, 1'b0);
		send_fields(CMD_STEP, 0, 0, 1'b0);
		send_fields(CMD_WRITE, GRID_COLS - 1, GRID_ROWS - 1, 1'b0); // cut it in two
		send_fields(CMD_STEP, 0, 0, 1'b0);                        // both ends starve
		// 2x2 block across the corner: still life
		send_fields(CMD_WRITE, GRID_COLS - 1, GRID_ROWS - 1, 1'b1);
		send_fields(CMD_WRITE, 0, GRID_ROWS - 1, 1'b1);
		send_fields(CMD_WRITE, GRID_COLS - 1, 0, 1'b1);
		send_fields(CMD_WRITE, 0, 0, 1'b1);
		send_fields(CMD_STEP, 0, 0, 1'b0);
		send_fields(CMD_READ, 0, 0, 1'b0);
	endtask

	// Seed a patch (wrapping at the edges) and let it evolve, with reads
	// into it and a little noise including the unused code.
	task automatic test_colonies(input int unsigned n_cmds);
		int unsigned sent, cr, cc, k, live_pct;
		sent = 0;
		while (sent < n_cmds) begin
			if ($urandom_range(99) < 12) begin
				repeat ($urandom_range(1, 4)) begin
					send_fields(2'($urandom_range(3)), $urandom_range(GRID_COLS - 1),
						$urandom_range(GRID_ROWS - 1), 1'($urandom));
					sent++;
				end
			end else begin
				cr = $urandom_range(GRID_ROWS - 1);
				cc = $urandom_range(GRID_COLS - 1);
				live_pct = $urandom_range(30, 70);
				k = $urandom_range(6, 28);
				repeat (k) begin
					send_fields(CMD_WRITE, (cc + $urandom_range(7)) % GRID_COLS,
						(cr + $urandom_range(5)) % GRID_ROWS,
						$urandom_range(99) < live_pct);
					sent++;
				end
				repeat ($urandom_range(1, 6)) begin
					send_fields(CMD_STEP, $urandom_range(GRID_COLS - 1),
						$urandom_range(GRID_ROWS - 1), 1'($urandom));
					sent++;
					repeat ($urandom_range(0, 3)) begin
						send_fields(CMD_READ, (cc + $urandom_range(9)) % GRID_COLS,
							(cr + $urandom_range(7)) % GRID_ROWS, 1'($urandom));
						sent++;
					end
				end
			end
		end
	endtask

	// Both sides at full rate: back-to-back steps and reads.
	task automatic test_full_rate(input int unsigned n_cmds);
		send_idle_pct = 0;
		res_idle_pct  = 0;
		test_colonies(n_cmds);
		send_idle_pct = IDLE_PCT;
		res_idle_pct  = IDLE_PCT;
	endtask

	// Sender holds off until nothing is owed, then carries on.
	task automatic test_drain_pause();
		test_colonies(60);
		drain_results();
		test_colonies(60);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int unsigned r = 0; r < GRID_ROWS; r++)
			shadow_grid[r] = '0;

		test_directed();
		test_colonies(650);
		test_full_rate(300);
		test_drain_pause();
		test_colonies(480);

		drain_results();
		// further edges catch any stray result
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS life_automaton_torus_step_unit");
		else
			$display("FAIL life_automaton_torus_step_unit");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("FAIL life_automaton_torus_step_unit");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/lats_pkg.sv
rtl/core/lats_row_cell.sv
rtl/core/life_automaton_torus_step_unit.sv
rtl/core/lats_checker.sv
test/tb_top.sv
